// File: src/erm_pkg.sv
// ----------------------------------------------------------------------------
// Euler rotation matrix package
// Shared widths, fixed-point constants, beat types and arithmetic helpers.
// ----------------------------------------------------------------------------
package erm_pkg;

   localparam int ANGLE_WIDTH = 16;
   localparam int COEF_WIDTH  = 16;
   localparam int ANG_FRAC    = ANGLE_WIDTH - 4;
   localparam int OUT_FRAC    = COEF_WIDTH - 2;
   localparam int ANG_SHIFT   = 30 - ANG_FRAC;
   localparam int OUT_SHIFT   = 30 - OUT_FRAC;

   // Range reduction, CORDIC datapath, product operand, product and sum widths.
   localparam int RW = 36;
   localparam int ZW = 34;
   localparam int XW = 34;
   localparam int PW = 32;
   localparam int MW = 34;
   localparam int SW = 36;

   localparam int STEPS = 31;
   localparam int QDEPTH = 4;
   localparam int QAW = 2;
   localparam int QCW = 3;

   localparam logic signed [RW-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [RW-1:0] TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [RW-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [XW-1:0] GAIN_INV    = 34'sd652032874;

   localparam logic signed [SW-1:0] OUT_HALF  = SW'((64'd1 << OUT_SHIFT) >> 1);
   localparam logic signed [SW-1:0] OUT_LIMIT = SW'(64'd1 << OUT_FRAC);

   typedef struct packed {
      logic signed [ANGLE_WIDTH-1:0] angle_x;
      logic signed [ANGLE_WIDTH-1:0] angle_y;
      logic signed [ANGLE_WIDTH-1:0] angle_z;
   } req_type;

   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] m00;
      logic signed [COEF_WIDTH-1:0] m01;
      logic signed [COEF_WIDTH-1:0] m02;
      logic signed [COEF_WIDTH-1:0] m10;
      logic signed [COEF_WIDTH-1:0] m11;
      logic signed [COEF_WIDTH-1:0] m12;
      logic signed [COEF_WIDTH-1:0] m20;
      logic signed [COEF_WIDTH-1:0] m21;
      logic signed [COEF_WIDTH-1:0] m22;
   } rsp_type;

   // One reduced angle: residue in [-pi/2, pi/2] and the quadrant sign flip.
   typedef struct packed {
      logic signed [ZW-1:0] r;
      logic                 neg;
   } lane_type;

   // Lane 0 is x, lane 1 is y, lane 2 is z.
   typedef lane_type [2:0] item_type;

   function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
      logic signed [ZW-1:0] v;
      case (idx)
         5'd0:  v = 34'sd843314857;
         5'd1:  v = 34'sd497837829;
         5'd2:  v = 34'sd263043837;
         5'd3:  v = 34'sd133525159;
         5'd4:  v = 34'sd67021687;
         5'd5:  v = 34'sd33543516;
         5'd6:  v = 34'sd16775851;
         5'd7:  v = 34'sd8388437;
         5'd8:  v = 34'sd4194283;
         5'd9:  v = 34'sd2097149;
         default: v = ZW'(64'd1 << (30 - int'(idx)));
      endcase
      return v;
   endfunction

   // Widens an angle to Q.30 and wraps it into [0, 2pi).
   function automatic logic signed [RW-1:0] wrap_angle(
      input logic signed [ANGLE_WIDTH-1:0] ang);
      logic signed [RW-1:0] a;
      logic signed [RW-1:0] r;
      a = RW'(ang) <<< ANG_SHIFT;
      if (a >= TWO_PI_Q30) begin
         r = a - TWO_PI_Q30;
      end else if (a < 0) begin
         r = (a + TWO_PI_Q30 < 0) ? a + TWO_PI_Q30 + TWO_PI_Q30 : a + TWO_PI_Q30;
      end else begin
         r = a;
      end
      return r;
   endfunction

   // Folds a wrapped angle into [-pi/2, pi/2] and marks the sign flip.
   function automatic lane_type fold_angle(input logic signed [RW-1:0] w);
      logic signed [RW-1:0] r;
      lane_type             o;
      r = (w > PI_Q30) ? w - TWO_PI_Q30 : w;
      o.neg = 1'b0;
      if (r > HALF_PI_Q30) begin
         r = r - PI_Q30;
         o.neg = 1'b1;
      end else if (r < -HALF_PI_Q30) begin
         r = r + PI_Q30;
         o.neg = 1'b1;
      end
      o.r = r[ZW-1:0];
      return o;
   endfunction

   // Q.30 product with round half up.
   function automatic logic signed [MW-1:0] mul30(input logic signed [PW-1:0] a,
                                                  input logic signed [PW-1:0] b);
      logic signed [2*PW-1:0] p;
      p = (2*PW)'(a) * (2*PW)'(b) + (2*PW)'(64'sd536870912);
      return MW'(p >>> 30);
   endfunction

   function automatic logic signed [PW-1:0] to_op(input logic signed [MW-1:0] v);
      return v[PW-1:0];
   endfunction

   // Rounds a Q.30 value to the output format and clamps it to +-1.0.
   function automatic logic signed [COEF_WIDTH-1:0] to_out(
      input logic signed [SW-1:0] v);
      logic signed [SW-1:0] t;
      t = (v + OUT_HALF) >>> OUT_SHIFT;
      if (t > OUT_LIMIT) begin
         t = OUT_LIMIT;
      end else if (t < -OUT_LIMIT) begin
         t = -OUT_LIMIT;
      end
      return t[COEF_WIDTH-1:0];
   endfunction

endpackage

// File: src/erm_front.sv
// ----------------------------------------------------------------------------
// Euler rotation matrix front end
// Takes angle beats and reduces each angle to a quadrant residue in two stages.
// ----------------------------------------------------------------------------
module erm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  erm_pkg::req_type  in_data,
   output logic              f1_valid,
   output logic              f2_valid,
   output erm_pkg::item_type f2_item
);

   logic                           v1_ff;
   logic                           v2_ff;
   logic signed [erm_pkg::RW-1:0]  w_ff [3];
   logic signed [erm_pkg::RW-1:0]  w_in [3];
   erm_pkg::item_type              item_ff;
   erm_pkg::item_type              item_in;

   always_comb begin
      w_in[0] = erm_pkg::wrap_angle(in_data.angle_x);
      w_in[1] = erm_pkg::wrap_angle(in_data.angle_y);
      w_in[2] = erm_pkg::wrap_angle(in_data.angle_z);
      for (int l = 0; l < 3; l++) begin
         item_in[l] = erm_pkg::fold_angle(w_ff[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      w_ff    <= w_in;
      item_ff <= item_in;
   end

   assign f1_valid = v1_ff;
   assign f2_valid = v2_ff;
   assign f2_item  = item_ff;

endmodule

// File: src/erm_queue.sv
// ----------------------------------------------------------------------------
// Euler rotation matrix queue
// Short register queue between the reduction front end and the CORDIC back end.
// ----------------------------------------------------------------------------
module erm_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr,
   input  erm_pkg::item_type       wr_item,
   output logic                    rd,
   output erm_pkg::item_type       rd_item,
   output logic [erm_pkg::QCW-1:0] count
);

   erm_pkg::item_type           mem_ff [erm_pkg::QDEPTH];
   logic [erm_pkg::QAW-1:0]     wp_ff;
   logic [erm_pkg::QAW-1:0]     rp_ff;
   logic [erm_pkg::QCW-1:0]     cnt_ff;
   logic [erm_pkg::QCW-1:0]     cnt_in;

   // The back end never stalls, so any stored beat leaves at once.
   assign rd      = (cnt_ff != '0);
   assign rd_item = mem_ff[rp_ff];
   assign count   = cnt_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (wr && !rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!wr && rd) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (wr) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (rd) begin
            rp_ff <= rp_ff + 1'b1;
         end
      end
      if (wr) begin
         mem_ff[wp_ff] <= wr_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= erm_pkg::QCW'(erm_pkg::QDEPTH))
      else $error("queue count exceeds depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(wr && !rd && cnt_ff == erm_pkg::QCW'(erm_pkg::QDEPTH)))
      else $error("queue written while full");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (wr && !rd) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("queue count did not advance on write");

endmodule

// File: src/erm_back.sv
// ----------------------------------------------------------------------------
// Euler rotation matrix back end
// Pipelined CORDIC sine and cosine for three angles, then the matrix products.
// ----------------------------------------------------------------------------
module erm_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  erm_pkg::item_type in_item,
   output logic              out_valid,
   output erm_pkg::rsp_type  out_data
);

   localparam int N = erm_pkg::STEPS;

   logic signed [erm_pkg::XW-1:0] x_ff [3][N+1];
   logic signed [erm_pkg::XW-1:0] y_ff [3][N+1];
   logic signed [erm_pkg::ZW-1:0] z_ff [3][N+1];
   logic                          n_ff [3][N+1];
   logic [N+4:0]                  v_ff;

   logic signed [erm_pkg::PW-1:0] sn_ff [3];
   logic signed [erm_pkg::PW-1:0] cs_ff [3];

   // First product stage.
   logic signed [erm_pkg::MW-1:0] czsy_ff, szsy_ff, czcy_ff, szcy_ff, cysx_ff, cycx_ff;
   logic signed [erm_pkg::MW-1:0] szcx_ff, czcx_ff, szsx_ff, czsx_ff;
   logic signed [erm_pkg::PW-1:0] sx1_ff, cx1_ff, sy1_ff;
   // Second product stage.
   logic signed [erm_pkg::MW-1:0] t10_ff, t11_ff, t20_ff, t21_ff;
   logic signed [erm_pkg::MW-1:0] czcy2_ff, szcy2_ff, cysx2_ff, cycx2_ff;
   logic signed [erm_pkg::MW-1:0] szcx2_ff, czcx2_ff, szsx2_ff, czsx2_ff;
   logic signed [erm_pkg::PW-1:0] sy2_ff;

   erm_pkg::rsp_type out_ff;
   erm_pkg::rsp_type out_in;

   genvar l, i;
   generate
      for (l = 0; l < 3; l++) begin : g_lane
         always_ff @(posedge clock) begin
            x_ff[l][0] <= erm_pkg::GAIN_INV;
            y_ff[l][0] <= '0;
            z_ff[l][0] <= in_item[l].r;
            n_ff[l][0] <= in_item[l].neg;
         end
         for (i = 0; i < N; i++) begin : g_step
            logic signed [erm_pkg::XW-1:0] x_in;
            logic signed [erm_pkg::XW-1:0] y_in;
            logic signed [erm_pkg::ZW-1:0] z_in;
            always_comb begin
               if (z_ff[l][i] >= 0) begin
                  x_in = x_ff[l][i] - (y_ff[l][i] >>> i);
                  y_in = y_ff[l][i] + (x_ff[l][i] >>> i);
                  z_in = z_ff[l][i] - erm_pkg::atan_q30(5'(i));
               end else begin
                  x_in = x_ff[l][i] + (y_ff[l][i] >>> i);
                  y_in = y_ff[l][i] - (x_ff[l][i] >>> i);
                  z_in = z_ff[l][i] + erm_pkg::atan_q30(5'(i));
               end
            end
            always_ff @(posedge clock) begin
               x_ff[l][i+1] <= x_in;
               y_ff[l][i+1] <= y_in;
               z_ff[l][i+1] <= z_in;
               n_ff[l][i+1] <= n_ff[l][i];
            end
         end
         always_ff @(posedge clock) begin
            cs_ff[l] <= n_ff[l][N] ? -x_ff[l][N][erm_pkg::PW-1:0]
                                   : x_ff[l][N][erm_pkg::PW-1:0];
            sn_ff[l] <= n_ff[l][N] ? -y_ff[l][N][erm_pkg::PW-1:0]
                                   : y_ff[l][N][erm_pkg::PW-1:0];
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      czsy_ff <= erm_pkg::mul30(cs_ff[2], sn_ff[1]);
      szsy_ff <= erm_pkg::mul30(sn_ff[2], sn_ff[1]);
      czcy_ff <= erm_pkg::mul30(cs_ff[2], cs_ff[1]);
      szcy_ff <= erm_pkg::mul30(sn_ff[2], cs_ff[1]);
      cysx_ff <= erm_pkg::mul30(cs_ff[1], sn_ff[0]);
      cycx_ff <= erm_pkg::mul30(cs_ff[1], cs_ff[0]);
      szcx_ff <= erm_pkg::mul30(sn_ff[2], cs_ff[0]);
      czcx_ff <= erm_pkg::mul30(cs_ff[2], cs_ff[0]);
      szsx_ff <= erm_pkg::mul30(sn_ff[2], sn_ff[0]);
      czsx_ff <= erm_pkg::mul30(cs_ff[2], sn_ff[0]);
      sx1_ff  <= sn_ff[0];
      cx1_ff  <= cs_ff[0];
      sy1_ff  <= sn_ff[1];

      t10_ff   <= erm_pkg::mul30(erm_pkg::to_op(czsy_ff), sx1_ff);
      t11_ff   <= erm_pkg::mul30(erm_pkg::to_op(szsy_ff), sx1_ff);
      t20_ff   <= erm_pkg::mul30(erm_pkg::to_op(czsy_ff), cx1_ff);
      t21_ff   <= erm_pkg::mul30(erm_pkg::to_op(szsy_ff), cx1_ff);
      czcy2_ff <= czcy_ff;
      szcy2_ff <= szcy_ff;
      cysx2_ff <= cysx_ff;
      cycx2_ff <= cycx_ff;
      szcx2_ff <= szcx_ff;
      czcx2_ff <= czcx_ff;
      szsx2_ff <= szsx_ff;
      czsx2_ff <= czsx_ff;
      sy2_ff   <= sy1_ff;

      out_ff <= out_in;
   end

   always_comb begin
      out_in.m00 = erm_pkg::to_out(erm_pkg::SW'(czcy2_ff));
      out_in.m01 = erm_pkg::to_out(erm_pkg::SW'(szcy2_ff));
      out_in.m02 = erm_pkg::to_out(-erm_pkg::SW'(sy2_ff));
      out_in.m10 = erm_pkg::to_out(erm_pkg::SW'(t10_ff) - erm_pkg::SW'(szcx2_ff));
      out_in.m11 = erm_pkg::to_out(erm_pkg::SW'(t11_ff) + erm_pkg::SW'(czcx2_ff));
      out_in.m12 = erm_pkg::to_out(erm_pkg::SW'(cysx2_ff));
      out_in.m20 = erm_pkg::to_out(erm_pkg::SW'(t20_ff) + erm_pkg::SW'(szsx2_ff));
      out_in.m21 = erm_pkg::to_out(erm_pkg::SW'(t21_ff) - erm_pkg::SW'(czsx2_ff));
      out_in.m22 = erm_pkg::to_out(erm_pkg::SW'(cycx2_ff));
   end

   // Valid travels alongside the data: CORDIC entry, 31 steps, sign, two products, output.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[N+3:0], in_valid};
      end
   end

   assign out_valid = v_ff[N+4];
   assign out_data  = out_ff;

   a_m11_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_data.m11 <= erm_pkg::COEF_WIDTH'(erm_pkg::OUT_LIMIT)
                  && out_data.m11 >= -erm_pkg::COEF_WIDTH'(erm_pkg::OUT_LIMIT)))
      else $error("m11 outside unit range");

   a_m20_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_data.m20 <= erm_pkg::COEF_WIDTH'(erm_pkg::OUT_LIMIT)
                  && out_data.m20 >= -erm_pkg::COEF_WIDTH'(erm_pkg::OUT_LIMIT)))
      else $error("m20 outside unit range");

endmodule

// File: src/euler_rotation_matrix.sv
// Throughput: one beat per cycle while busy is low; the CORDIC and product pipelines are fully registered.
// busy rises only if the four-entry queue plus the two reduction stages would overflow.
// Synchronous active-high reset clears all valid state; no results are pending after it.
// The result is shown for one cycle under rsp_valid and cannot be held off.
// ----------------------------------------------------------------------------
// Euler rotation matrix
// Turns x, y, z rotation angles into the nine entries of a 3x3 rotation matrix.
// ----------------------------------------------------------------------------
module euler_rotation_matrix (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  erm_pkg::req_type req_data,
   output logic             rsp_valid,
   output erm_pkg::rsp_type rsp_data
);

   logic                    f1_valid;
   logic                    f2_valid;
   erm_pkg::item_type       f2_item;
   logic                    q_rd;
   erm_pkg::item_type       q_item;
   logic [erm_pkg::QCW-1:0] q_count;
   logic [erm_pkg::QCW:0]   pending;

   // Beats in the reduction stages hold a reserved queue slot.
   assign pending = {1'b0, q_count} + {{erm_pkg::QCW{1'b0}}, f1_valid}
                  + {{erm_pkg::QCW{1'b0}}, f2_valid};
   assign busy    = (pending >= (erm_pkg::QCW+1)'(erm_pkg::QDEPTH));

   erm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .in_data  (req_data),
      .f1_valid (f1_valid),
      .f2_valid (f2_valid),
      .f2_item  (f2_item)
   );

   erm_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr      (f2_valid),
      .wr_item (f2_item),
      .rd      (q_rd),
      .rd_item (q_item),
      .count   (q_count)
   );

   erm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_rd),
      .in_item   (q_item),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule
